// ----- rtl/cagn_pkg.sv -----
`timescale 1ns / 1ps

package cagn_pkg;

  localparam int unsigned THR_W     = 9;
  localparam logic [THR_W-1:0] THR_RESET = 9'd115;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned SIZE_W  = 15;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned AREA_W  = 2 * SIZE_W;

  typedef struct packed {
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
    logic [SIZE_W-1:0]  height;
    logic [SIZE_W-1:0]  width;
    logic [LABEL_W-1:0] label;
  } box_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } cmp_stat_t;

endpackage

// ----- rtl/cagn_iou_cmp.sv -----
`timescale 1ns / 1ps

module cagn_iou_cmp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  cagn_pkg::box_t               cand_i,
  input  cagn_pkg::box_t               kept_i,
  input  logic [cagn_pkg::THR_W-1:0]   thr_i,
  output cagn_pkg::cmp_stat_t          stat_o
);
  import cagn_pkg::*;

  localparam int unsigned EDGE_W = COORD_W + 2;
  localparam int unsigned UNI_W  = AREA_W + 1;
  localparam int unsigned PROD_W = THR_W + UNI_W;

  // stage 0: overlap extents
  logic signed [EDGE_W-1:0] a_l, a_t, a_r, a_b, b_l, b_t, b_r, b_b;
  logic signed [EDGE_W-1:0] i_l, i_t, i_r, i_b, dx, dy;

  logic              s0_vld_q, s0_same_q;
  logic [SIZE_W-1:0] s0_dx_q, s0_dy_q, s0_bw_q, s0_bh_q;

  always_comb begin
    a_l = {{2{cand_i.left[COORD_W-1]}}, cand_i.left};
    a_t = {{2{cand_i.top[COORD_W-1]}}, cand_i.top};
    b_l = {{2{kept_i.left[COORD_W-1]}}, kept_i.left};
    b_t = {{2{kept_i.top[COORD_W-1]}}, kept_i.top};
    a_r = a_l + {3'b000, cand_i.width};
    a_b = a_t + {3'b000, cand_i.height};
    b_r = b_l + {3'b000, kept_i.width};
    b_b = b_t + {3'b000, kept_i.height};
    i_l = (a_l > b_l) ? a_l : b_l;
    i_t = (a_t > b_t) ? a_t : b_t;
    i_r = (a_r < b_r) ? a_r : b_r;
    i_b = (a_b < b_b) ? a_b : b_b;
    dx  = i_r - i_l;
    dy  = i_b - i_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_same_q <= (cand_i.label == kept_i.label);
    s0_dx_q   <= dx[EDGE_W-1] ? '0 : dx[SIZE_W-1:0];
    s0_dy_q   <= dy[EDGE_W-1] ? '0 : dy[SIZE_W-1:0];
    s0_bw_q   <= kept_i.width;
    s0_bh_q   <= kept_i.height;
  end

  // stage 1: areas
  logic              s1_vld_q, s1_same_q;
  logic [AREA_W-1:0] s1_inter_q, s1_area_b_q, area_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_same_q   <= s0_same_q;
    s1_inter_q  <= AREA_W'(s0_dx_q) * AREA_W'(s0_dy_q);
    s1_area_b_q <= AREA_W'(s0_bw_q) * AREA_W'(s0_bh_q);
    area_a_q    <= AREA_W'(cand_i.width) * AREA_W'(cand_i.height);
  end

  // stage 2: union
  logic              s2_vld_q, s2_same_q;
  logic [AREA_W-1:0] s2_inter_q;
  logic [UNI_W-1:0]  s2_uni_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_same_q  <= s1_same_q;
    s2_inter_q <= s1_inter_q;
    s2_uni_q   <= {1'b0, area_a_q} + {1'b0, s1_area_b_q} - {1'b0, s1_inter_q};
  end

  // stage 3: threshold test
  logic              s3_vld_q, s3_hit_q;
  logic [PROD_W-1:0] lhs, rhs;

  always_comb begin
    lhs = PROD_W'({s2_inter_q, 8'h00});
    rhs = PROD_W'(thr_i) * PROD_W'(s2_uni_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s3_hit_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
      s3_hit_q <= s2_vld_q && s2_same_q && (s2_uni_q != '0) && (lhs > rhs);
    end
  end

  assign stat_o.busy = s0_vld_q | s1_vld_q | s2_vld_q | s3_vld_q;
  assign stat_o.hit  = s3_vld_q & s3_hit_q;

endmodule

// ----- rtl/class_aware_greedy_nms.sv -----
`timescale 1ns / 1ps

// Class-aware greedy non-maximum suppression. Boxes of a frame arrive in
// descending score order, one word each; every box yields one result word.
// A box is scanned against the boxes kept so far in the frame, which sit in
// a single-port synchronous memory of MAX_KEPT entries read one per cycle
// and fed to a four-stage IoU compare pipeline. No new box is accepted until
// the current one has closed. A kept box is written back in the closing
// cycle while the store has room; the result waits in an output register
// while the next box is already accepted. The user must write the threshold
// register only while the block is idle; the block itself does not enforce
// this. The threshold port is always ready.
module class_aware_greedy_nms #(
  parameter int unsigned MAX_KEPT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cagn_pkg::THR_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [15:0]            box_left_i,
  input  logic signed [15:0]            box_top_i,
  input  logic [14:0]                   box_width_i,
  input  logic [14:0]                   box_height_i,
  input  logic [7:0]                    class_label_i,
  input  logic                          last_box_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          keep_o,
  output logic                          store_full_o,
  output logic                          frame_end_o
);
  import cagn_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_KEPT + 1);
  localparam int unsigned IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEPT);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [THR_W-1:0] thr_q;
  logic [CNT_W-1:0] total_q, total_d, cnt_q, cnt_d;
  logic             keep_q, keep_d, last_q, rd_vld_q;
  logic             out_valid_q, out_valid_d, out_keep_q, out_full_q, out_end_q;
  box_t             cand_q, rd_data_q;
  box_t             kept_mem [MAX_KEPT];

  logic      in_fire, rd_en, wr_en, done_fire, out_free;
  cmp_stat_t stat;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign rd_en       = (state_q == ST_SCAN) && (cnt_q < total_q);
  assign done_fire   = (state_q == ST_DONE) && out_free;
  assign wr_en       = done_fire && keep_q && (total_q < MAX_CNT);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    keep_d      = keep_q;
    total_d     = total_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (stat.hit) begin
      keep_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          keep_d  = 1'b1;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else if (!rd_vld_q && !stat.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          if (last_q) begin
            total_d = '0;
          end else if (wr_en) begin
            total_d = total_q + CNT_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THR_RESET;
      total_q     <= '0;
      cnt_q       <= '0;
      keep_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      keep_q      <= keep_d;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cand_q.left   <= box_left_i;
      cand_q.top    <= box_top_i;
      cand_q.width  <= box_width_i;
      cand_q.height <= box_height_i;
      cand_q.label  <= class_label_i;
      last_q        <= last_box_i;
    end
    if (done_fire) begin
      out_keep_q <= keep_q;
      out_full_q <= keep_q && (total_q >= MAX_CNT);
      out_end_q  <= last_q;
    end
  end

  // kept box store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      kept_mem[total_q[IDX_W-1:0]] <= cand_q;
    end
    if (rd_en) begin
      rd_data_q <= kept_mem[cnt_q[IDX_W-1:0]];
    end
  end

  cagn_iou_cmp u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .cand_i (cand_q),
    .kept_i (rd_data_q),
    .thr_i  (thr_q),
    .stat_o (stat)
  );

  assign out_valid_o  = out_valid_q;
  assign keep_o       = out_keep_q;
  assign store_full_o = out_full_q;
  assign frame_end_o  = out_end_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= MAX_CNT)
    else $error("kept count beyond store size");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (cnt_q < total_q) && (state_q == ST_SCAN))
    else $error("store read beyond kept count");

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && last_q) |=> (total_q == '0) && out_valid_q && out_end_q)
    else $error("store not cleared after last box");

  a_full_implies_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!store_full_o || keep_o))
    else $error("store full flagged on suppressed box");

  a_no_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (!stat.busy && !rd_vld_q))
    else $error("result closed while compares in flight");

endmodule

// ----- bench/class_aware_greedy_nms_test.sv -----
`timescale 1ns / 1ps

module class_aware_greedy_nms_test;
  import cagn_pkg::*;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned TAIL_CYCLES = 120;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic keep;
    logic full;
    logic frame_end;
  } verdict_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [THR_W-1:0]     cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic signed [15:0]   box_left_i    = '0;
  logic signed [15:0]   box_top_i     = '0;
  logic [14:0]          box_width_i   = '0;
  logic [14:0]          box_height_i  = '0;
  logic [7:0]           class_label_i = '0;
  logic                 last_box_i    = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic                 keep_o;
  logic                 store_full_o;
  logic                 frame_end_o;

  // own copy of the kept-box store and the threshold
  box_t                 kept_boxes [STORE_DEPTH];
  int unsigned          kept_count = 0;
  int unsigned          iou_thr    = 32'(THR_RESET);

  verdict_t             expected_verdicts [$];
  int unsigned          fail_count   = 0;
  int unsigned          cycle_count  = 0;
  int unsigned          in_idle_pct  = 0;
  int unsigned          out_idle_pct = 0;
  int unsigned          boxes_sent   = 0;
  int unsigned          boxes_kept   = 0;
  int unsigned          boxes_dropped = 0;
  int unsigned          boxes_unstored = 0;
  int unsigned          frames_sent  = 0;
  int unsigned          thr_writes   = 0;

  class_aware_greedy_nms #(
    .MAX_KEPT(STORE_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .box_left_i   (box_left_i),
    .box_top_i    (box_top_i),
    .box_width_i  (box_width_i),
    .box_height_i (box_height_i),
    .class_label_i(class_label_i),
    .last_box_i   (last_box_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .keep_o       (keep_o),
    .store_full_o (store_full_o),
    .frame_end_o  (frame_end_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("mismatch: %s", msg);
  endtask

  function automatic box_t make_box(input int l, input int t, input int w, input int h,
                                    input int lab);
    box_t b;
    b.left   = 16'(l);
    b.top    = 16'(t);
    b.width  = 15'(w);
    b.height = 15'(h);
    b.label  = 8'(lab);
    return b;
  endfunction

  // greedy suppression of one box against the boxes kept in this frame
  function automatic verdict_t judge_box(input box_t b, input bit last);
    verdict_t v;
    longint al, at, aw, ah, bl, bt, bw, bh;
    longint il, it, ir, ib, inter, uni, area_a;
    al = longint'($signed(b.left));
    at = longint'($signed(b.top));
    aw = longint'(b.width);
    ah = longint'(b.height);
    area_a = aw * ah;
    v.keep = 1'b1;
    v.full = 1'b0;
    v.frame_end = last;
    for (int unsigned j = 0; j < kept_count; j++) begin
      bl = longint'($signed(kept_boxes[j].left));
      bt = longint'($signed(kept_boxes[j].top));
      bw = longint'(kept_boxes[j].width);
      bh = longint'(kept_boxes[j].height);
      il = (al > bl) ? al : bl;
      it = (at > bt) ? at : bt;
      ir = (al + aw < bl + bw) ? al + aw : bl + bw;
      ib = (at + ah < bt + bh) ? at + ah : bt + bh;
      inter = (ir >= il && ib >= it) ? (ir - il) * (ib - it) : 0;
      uni = area_a + bw * bh - inter;
      if (uni > 0 && inter * 256 > longint'(iou_thr) * uni &&
          kept_boxes[j].label == b.label) begin
        v.keep = 1'b0;
      end
    end
    if (v.keep) begin
      if (kept_count < STORE_DEPTH) begin
        kept_boxes[kept_count] = b;
        kept_count++;
      end else begin
        v.full = 1'b1;
      end
    end
    if (last) begin
      kept_count = 0;
      frames_sent++;
    end
    boxes_sent++;
    if (!v.keep) boxes_dropped++;
    else boxes_kept++;
    if (v.full) boxes_unstored++;
    return v;
  endfunction

  task automatic send_box(input box_t b, input bit last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    box_left_i    <= b.left;
    box_top_i     <= b.top;
    box_width_i   <= b.width;
    box_height_i  <= b.height;
    class_label_i <= b.label;
    last_box_i    <= last;
    expected_verdicts.insert(expected_verdicts.size(), judge_box(b, last));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input int unsigned value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= THR_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    iou_thr = value & 9'h1FF;
    thr_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one result word per box, checked against the oldest prediction
  always @(posedge clk_i) begin : verdict_check
    verdict_t got;
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{keep_o, store_full_o, frame_end_o};
      if (expected_verdicts.size() == 0) begin
        note_failure($sformatf("result word with none expected: keep=%b full=%b end=%b",
                               got.keep, got.full, got.frame_end));
      end else begin
        want = expected_verdicts.pop_front();
        if (got.keep !== want.keep || got.full !== want.full ||
            got.frame_end !== want.frame_end) begin
          note_failure($sformatf("keep %b/%b full %b/%b end %b/%b (expected/actual)",
                                 want.keep, got.keep, want.full, got.full,
                                 want.frame_end, got.frame_end));
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  task automatic test_extremes;
    send_box(make_box(-32768, -32768, 32767, 32767, 0), 1'b0);
    send_box(make_box(-32768, -32768, 32767, 32767, 0), 1'b0);
    send_box(make_box(-32768, -32768, 32767, 32767, 255), 1'b0);
    send_box(make_box(32767, 32767, 32767, 32767, 255), 1'b0);
    send_box(make_box(32767, 32767, 32767, 32767, 255), 1'b0);
    // zero area pair gives an empty union
    send_box(make_box(0, 0, 0, 0, 7), 1'b0);
    send_box(make_box(0, 0, 0, 0, 7), 1'b0);
    send_box(make_box(100, 100, 50, 50, 7), 1'b1);
  endtask

  task automatic test_touching_edges;
    send_box(make_box(0, 0, 100, 100, 1), 1'b0);
    send_box(make_box(100, 0, 100, 100, 1), 1'b0);
    send_box(make_box(0, 100, 100, 100, 1), 1'b0);
    send_box(make_box(500, 500, 100, 100, 1), 1'b0);
    send_box(make_box(50, 50, 100, 100, 1), 1'b0);
    send_box(make_box(10, 10, 100, 100, 1), 1'b1);
  endtask

  task automatic test_threshold_limits;
    write_threshold(0);
    send_box(make_box(0, 0, 10, 10, 2), 1'b0);
    send_box(make_box(9, 9, 10, 10, 2), 1'b0);
    send_box(make_box(20, 20, 10, 10, 2), 1'b1);
    write_threshold(256);
    send_box(make_box(0, 0, 10, 10, 3), 1'b0);
    send_box(make_box(0, 0, 10, 10, 3), 1'b1);
    write_threshold(255);
    send_box(make_box(0, 0, 10, 10, 4), 1'b0);
    send_box(make_box(0, 0, 10, 10, 4), 1'b1);
    // iou exactly at the threshold does not suppress
    write_threshold(128);
    send_box(make_box(0, 0, 10, 10, 5), 1'b0);
    send_box(make_box(0, 0, 10, 5, 5), 1'b1);
    write_threshold(32'(THR_RESET));
  endtask

  task automatic test_store_full;
    for (int i = 0; i < STORE_DEPTH + 2; i++) begin
      send_box(make_box(i * 200, 0, 100, 100, 9), 1'b0);
    end
    send_box(make_box(0, 0, 100, 100, 9), 1'b0);
    send_box(make_box(STORE_DEPTH * 200, 0, 100, 100, 9), 1'b1);
    send_box(make_box(0, 0, 100, 100, 9), 1'b1);
  endtask

  function automatic box_t random_box(input box_t prev, input bit have_prev,
                                      input logic [15:0] cx, input logic [15:0] cy,
                                      input bit wide);
    box_t b;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      b.left   = 16'($urandom);
      b.top    = 16'($urandom);
      b.width  = 15'($urandom);
      b.height = 15'($urandom);
      b.label  = 8'($urandom);
    end else if (pick < 40 && have_prev) begin
      b = prev;
      b.left   = prev.left + 16'($urandom_range(0, 40)) - 16'd20;
      b.top    = prev.top + 16'($urandom_range(0, 40)) - 16'd20;
      b.width  = prev.width + 15'($urandom_range(0, 30)) - 15'd15;
      b.height = prev.height + 15'($urandom_range(0, 30)) - 15'd15;
      if ($urandom_range(0, 4) == 0) b.label = wide ? 8'($urandom) : 8'($urandom_range(0, 3));
    end else begin
      b.left   = cx + 16'($urandom_range(0, 600)) - 16'd300;
      b.top    = cy + 16'($urandom_range(0, 600)) - 16'd300;
      b.width  = 15'($urandom_range(0, 400));
      b.height = 15'($urandom_range(0, 400));
      b.label  = wide ? 8'($urandom) : 8'($urandom_range(0, 3));
      if ($urandom_range(0, 15) == 0) b.width = '0;
      if ($urandom_range(0, 15) == 0) b.height = '0;
    end
    return b;
  endfunction

  task automatic test_random_frames(input int unsigned n_items, input int unsigned in_pct,
                                    input int unsigned out_pct);
    int unsigned sent;
    int unsigned frame_len;
    bit wide;
    bit have_prev;
    box_t prev;
    box_t b;
    logic [15:0] cx;
    logic [15:0] cy;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    sent = 0;
    prev = '0;
    while (sent < n_items) begin
      if ($urandom_range(0, 11) == 0) begin
        frame_len = $urandom_range(STORE_DEPTH, STORE_DEPTH + 16);
        wide = 1'b1;
      end else begin
        frame_len = $urandom_range(1, 20);
        wide = ($urandom_range(0, 3) == 0);
      end
      cx = 16'($urandom);
      cy = 16'($urandom);
      have_prev = 1'b0;
      for (int unsigned i = 0; i < frame_len; i++) begin
        b = random_box(prev, have_prev, cx, cy, wide);
        send_box(b, i == frame_len - 1);
        prev = b;
        have_prev = 1'b1;
        sent++;
      end
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 3) == 0) write_threshold($urandom_range(0, 1) ? 256 : 0);
        else write_threshold($urandom_range(0, 256));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    in_idle_pct  = 17;
    out_idle_pct = 80;
    test_extremes();
    test_touching_edges();
    test_threshold_limits();
    test_store_full();
    test_random_frames(340, 17, 80);
    write_threshold(32'(THR_RESET));
    test_random_frames(340, 80, 17);
    write_threshold($urandom_range(1, 255));
    test_random_frames(340, 0, 0);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_verdicts.size() != 0) begin
      note_failure($sformatf("%0d result words never arrived", expected_verdicts.size()));
    end
    $display("covered %0d boxes in %0d frames: %0d kept, %0d suppressed, %0d not stored",
             boxes_sent, frames_sent, boxes_kept, boxes_dropped, boxes_unstored);
    $display("threshold written %0d times, %0d failures", thr_writes, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cagn_pkg.sv
rtl/cagn_iou_cmp.sv
rtl/class_aware_greedy_nms.sv
bench/class_aware_greedy_nms_test.sv
